FILE: hdl/rci_pkg.sv
// shared widths, register codes, sideband types and saturation for the ray-cone block
`timescale 1ns / 1ps

package rci_pkg;

    localparam int WORD_BITS    = 32;
    localparam int FRAC_BITS    = 16;
    localparam int FIELD_BITS   = 32;
    localparam int ELEM_BITS    = 32;
    localparam int REG_BITS     = 64;
    localparam int REG_COUNT    = 6;
    localparam int CFG_IDX_BITS = 3;

    // transform products and their floored q32.16 form
    localparam int XP_BITS   = ELEM_BITS + WORD_BITS;
    localparam int XF_BITS   = XP_BITS - FRAC_BITS;
    // cone products
    localparam int CP_BITS   = 2 * WORD_BITS;
    localparam int CF_BITS   = CP_BITS - FRAC_BITS;
    // common width for sums ahead of saturation
    localparam int WIDE_BITS = XP_BITS + 2;

    localparam int RAD_BITS  = 2 * WORD_BITS;
    localparam int ROOT_BITS = WORD_BITS;
    localparam int NUM_BITS  = WORD_BITS + 2;
    localparam int MAG_BITS  = WORD_BITS + 1;
    localparam int DVD_BITS  = MAG_BITS + FRAC_BITS;

    localparam logic [CFG_IDX_BITS-1:0] IDX_ROW0_LO = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] IDX_ROW0_HI = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] IDX_ROW1_LO = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] IDX_ROW1_HI = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] IDX_ROW2_LO = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] IDX_ROW2_HI = 3'd5;

    localparam logic [REG_BITS-1:0] RST_ROW0_LO = 64'h0000_0001_0000_0000;
    localparam logic [REG_BITS-1:0] RST_ROW0_HI = 64'h0000_0000_0000_0000;
    localparam logic [REG_BITS-1:0] RST_ROW1_LO = 64'h0000_0000_0001_0000;
    localparam logic [REG_BITS-1:0] RST_ROW1_HI = 64'h0000_0000_0000_0000;
    localparam logic [REG_BITS-1:0] RST_ROW2_LO = 64'h0000_0000_0000_0000;
    localparam logic [REG_BITS-1:0] RST_ROW2_HI = 64'h0001_0000_0000_0000;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] h;
        logic signed [WORD_BITS-1:0] a;
        logic                        degen;
        logic                        e_ok;
    } sq_side_t;

    typedef struct packed {
        logic degen;
        logic e_ok;
    } dv_side_t;

    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-WORD_BITS:0]  upper;
        logic signed [WORD_BITS-1:0]   res;
        upper = v[WIDE_BITS-1:WORD_BITS-1];
        if ((&upper) || !(|upper))
            res = v[WORD_BITS-1:0];
        else if (v[WIDE_BITS-1])
            res = {1'b1, {(WORD_BITS-1){1'b0}}};
        else
            res = {1'b0, {(WORD_BITS-1){1'b1}}};
        return res;
    endfunction

endpackage

FILE: hdl/rci_sqrt.sv
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module rci_sqrt (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [rci_pkg::RAD_BITS-1:0]      rad,
    input  rci_pkg::sq_side_t                 in_side,
    output logic                              out_vld,
    output logic [rci_pkg::ROOT_BITS-1:0]     root,
    output rci_pkg::sq_side_t                 out_side
);
    import rci_pkg::*;

    localparam int STEPS    = ROOT_BITS;
    localparam int REM_BITS = ROOT_BITS + 2;
    localparam int TRY_BITS = REM_BITS + 2;

    logic [REM_BITS-1:0]  rem_reg  [STEPS];
    logic [ROOT_BITS-1:0] root_reg [STEPS];
    logic [RAD_BITS-1:0]  rad_reg  [STEPS];
    sq_side_t             side_reg [STEPS];
    logic [STEPS-1:0]     vld_reg;

    logic [REM_BITS-1:0]  rem_next  [STEPS];
    logic [ROOT_BITS-1:0] root_next [STEPS];
    logic [RAD_BITS-1:0]  rad_next  [STEPS];

    always_comb
    begin
        logic [REM_BITS-1:0]  s_rem;
        logic [ROOT_BITS-1:0] s_root;
        logic [RAD_BITS-1:0]  s_rad;
        logic [TRY_BITS-1:0]  t_rem;
        logic [TRY_BITS-1:0]  t_sub;
        for (int i = 0; i < STEPS; i++)
        begin
            if (i == 0)
            begin
                s_rem  = '0;
                s_root = '0;
                s_rad  = rad;
            end
            else
            begin
                s_rem  = rem_reg[i-1];
                s_root = root_reg[i-1];
                s_rad  = rad_reg[i-1];
            end
            t_rem = {s_rem, s_rad[RAD_BITS-1 -: 2]};
            t_sub = {2'b00, s_root, 2'b01};
            if (t_rem >= t_sub)
            begin
                rem_next[i]  = REM_BITS'(t_rem - t_sub);
                root_next[i] = {s_root[ROOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = t_rem[REM_BITS-1:0];
                root_next[i] = {s_root[ROOT_BITS-2:0], 1'b0};
            end
            rad_next[i] = {s_rad[RAD_BITS-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[STEPS-2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < STEPS; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                rad_reg[i]  <= rad_next[i];
                side_reg[i] <= (i == 0) ? in_side : side_reg[i-1];
            end
        end
    end

    assign out_vld  = vld_reg[STEPS-1];
    assign root     = root_reg[STEPS-1];
    assign out_side = side_reg[STEPS-1];

endmodule

FILE: hdl/rci_div.sv
// two-lane pipelined signed divider for the roots, with saturation and hit masking
`timescale 1ns / 1ps

module rci_div (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_vld,
    input  logic signed [rci_pkg::NUM_BITS-1:0]    num_near,
    input  logic signed [rci_pkg::NUM_BITS-1:0]    num_far,
    input  logic signed [rci_pkg::WORD_BITS-1:0]   den,
    input  rci_pkg::dv_side_t                      in_side,
    output logic                                   out_vld,
    output logic                                   hit,
    output logic                                   degenerate,
    output logic signed [rci_pkg::FIELD_BITS-1:0]  t_near,
    output logic signed [rci_pkg::FIELD_BITS-1:0]  t_far
);
    import rci_pkg::*;

    localparam int STEPS = DVD_BITS;
    localparam int LANES = 2;

    // entry stage: magnitudes and quotient signs
    logic                 e_vld_reg;
    logic [DVD_BITS-1:0]  e_work_reg [LANES];
    logic [LANES-1:0]     e_neg_reg;
    logic [WORD_BITS-1:0] e_den_reg;
    dv_side_t             e_side_reg;

    logic [WORD_BITS-1:0] rem_reg  [STEPS][LANES];
    logic [DVD_BITS-1:0]  work_reg [STEPS][LANES];
    logic [LANES-1:0]     neg_reg  [STEPS];
    logic [WORD_BITS-1:0] den_reg  [STEPS];
    dv_side_t             side_reg [STEPS];
    logic [STEPS-1:0]     vld_reg;

    logic [WORD_BITS-1:0] rem_next  [STEPS][LANES];
    logic [DVD_BITS-1:0]  work_next [STEPS][LANES];

    logic                 o_vld_reg;
    logic                 o_hit_reg;
    logic                 o_degen_reg;
    logic signed [FIELD_BITS-1:0] o_near_reg;
    logic signed [FIELD_BITS-1:0] o_far_reg;

    logic signed [NUM_BITS-1:0]  num_in [LANES];
    logic [MAG_BITS-1:0]         mag    [LANES];
    logic signed [WORD_BITS-1:0] t_sat  [LANES];
    logic                        hit_last;

    assign num_in[0] = num_near;
    assign num_in[1] = num_far;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
            mag[l] = MAG_BITS'(num_in[l][NUM_BITS-1] ? -num_in[l] : num_in[l]);
    end

    // restoring division, one quotient bit per stage
    always_comb
    begin
        logic [WORD_BITS-1:0] s_rem;
        logic [DVD_BITS-1:0]  s_work;
        logic [WORD_BITS-1:0] s_den;
        logic [WORD_BITS:0]   trial;
        for (int i = 0; i < STEPS; i++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (i == 0)
                begin
                    s_rem  = '0;
                    s_work = e_work_reg[l];
                    s_den  = e_den_reg;
                end
                else
                begin
                    s_rem  = rem_reg[i-1][l];
                    s_work = work_reg[i-1][l];
                    s_den  = den_reg[i-1];
                end
                trial = {s_rem, s_work[DVD_BITS-1]};
                if (trial >= {1'b0, s_den})
                begin
                    rem_next[i][l]  = WORD_BITS'(trial - {1'b0, s_den});
                    work_next[i][l] = {s_work[DVD_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i][l]  = trial[WORD_BITS-1:0];
                    work_next[i][l] = {s_work[DVD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // sign, saturate
    always_comb
    begin
        logic signed [DVD_BITS:0] sq;
        for (int l = 0; l < LANES; l++)
        begin
            sq = $signed({1'b0, work_reg[STEPS-1][l]});
            if (neg_reg[STEPS-1][l])
                sq = -sq;
            t_sat[l] = sat_word(WIDE_BITS'(sq));
        end
    end

    assign hit_last = side_reg[STEPS-1].e_ok && !side_reg[STEPS-1].degen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            vld_reg   <= '0;
            o_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= in_vld;
            vld_reg   <= {vld_reg[STEPS-2:0], e_vld_reg};
            o_vld_reg <= vld_reg[STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                e_work_reg[l] <= {mag[l], {FRAC_BITS{1'b0}}};
                e_neg_reg[l]  <= num_in[l][NUM_BITS-1] ^ den[WORD_BITS-1];
            end
            e_den_reg  <= WORD_BITS'(den[WORD_BITS-1] ? -den : den);
            e_side_reg <= in_side;
            for (int i = 0; i < STEPS; i++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[i][l]  <= rem_next[i][l];
                    work_reg[i][l] <= work_next[i][l];
                end
                neg_reg[i]  <= (i == 0) ? e_neg_reg  : neg_reg[i-1];
                den_reg[i]  <= (i == 0) ? e_den_reg  : den_reg[i-1];
                side_reg[i] <= (i == 0) ? e_side_reg : side_reg[i-1];
            end
            o_hit_reg   <= hit_last;
            o_degen_reg <= side_reg[STEPS-1].degen;
            o_near_reg  <= hit_last ? FIELD_BITS'(t_sat[0]) : '0;
            o_far_reg   <= hit_last ? FIELD_BITS'(t_sat[1]) : '0;
        end
    end

    assign out_vld    = o_vld_reg;
    assign hit        = o_hit_reg;
    assign degenerate = o_degen_reg;
    assign t_near     = o_near_reg;
    assign t_far      = o_far_reg;

endmodule

FILE: hdl/ray_cone_intersect_top.sv
// top level: ray to double cone x^2 - y^2 + z^2 = 0 intersection pipeline
`timescale 1ns / 1ps

// takes one ray per clock while the output side keeps up and returns one result
// per ray, in order. the pipeline is made of the transform and quadratic stages,
// the square root (one root bit per stage, 32 stages) and the root divider (one
// quotient bit per stage, 49 stages). a stalled output freezes the whole
// pipeline, so in_ready drops only while a result waits and out_ready is low.
// the six 64-bit transform registers are written through the cfg channel
// (always ready) and must only change while the pipeline is empty. a zero
// quadratic term reports degenerate with no hit; roots are zero whenever hit
// is low.

module ray_cone_intersect_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // ray input
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [rci_pkg::FIELD_BITS-1:0]  orig_x,
    input  logic signed [rci_pkg::FIELD_BITS-1:0]  orig_y,
    input  logic signed [rci_pkg::FIELD_BITS-1:0]  orig_z,
    input  logic signed [rci_pkg::FIELD_BITS-1:0]  dir_x,
    input  logic signed [rci_pkg::FIELD_BITS-1:0]  dir_y,
    input  logic signed [rci_pkg::FIELD_BITS-1:0]  dir_z,
    // result output
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   hit,
    output logic                                   degenerate,
    output logic signed [rci_pkg::FIELD_BITS-1:0]  t_near,
    output logic signed [rci_pkg::FIELD_BITS-1:0]  t_far,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rci_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [rci_pkg::REG_BITS-1:0]           cfg_data
);
    import rci_pkg::*;

    // global advance: everything moves unless a result is held at the output
    logic en;

    // ---------------------------------------------------------------
    // transform registers
    // ---------------------------------------------------------------
    logic [REG_BITS-1:0] inv_reg [REG_COUNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg[IDX_ROW0_LO] <= RST_ROW0_LO;
            inv_reg[IDX_ROW0_HI] <= RST_ROW0_HI;
            inv_reg[IDX_ROW1_LO] <= RST_ROW1_LO;
            inv_reg[IDX_ROW1_HI] <= RST_ROW1_HI;
            inv_reg[IDX_ROW2_LO] <= RST_ROW2_LO;
            inv_reg[IDX_ROW2_HI] <= RST_ROW2_HI;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                IDX_ROW0_LO: inv_reg[IDX_ROW0_LO] <= cfg_data;
                IDX_ROW0_HI: inv_reg[IDX_ROW0_HI] <= cfg_data;
                IDX_ROW1_LO: inv_reg[IDX_ROW1_LO] <= cfg_data;
                IDX_ROW1_HI: inv_reg[IDX_ROW1_HI] <= cfg_data;
                IDX_ROW2_LO: inv_reg[IDX_ROW2_LO] <= cfg_data;
                IDX_ROW2_HI: inv_reg[IDX_ROW2_HI] <= cfg_data;
                default: ; // writes beyond the register list are dropped
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // matrix elements: lo word = columns 0/1, hi word = column 2/translation
    logic signed [ELEM_BITS-1:0] m [3][4];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            m[r][0] = inv_reg[CFG_IDX_BITS'(2 * r)][ELEM_BITS-1:0];
            m[r][1] = inv_reg[CFG_IDX_BITS'(2 * r)][2*ELEM_BITS-1:ELEM_BITS];
            m[r][2] = inv_reg[CFG_IDX_BITS'(2 * r + 1)][ELEM_BITS-1:0];
            m[r][3] = inv_reg[CFG_IDX_BITS'(2 * r + 1)][2*ELEM_BITS-1:ELEM_BITS];
        end
    end

    // ---------------------------------------------------------------
    // stage 1: transform products, each floored to q32.16; both factors are q16.16
    // ---------------------------------------------------------------
    logic signed [WORD_BITS-1:0] wo [3];
    logic signed [WORD_BITS-1:0] wd [3];
    logic signed [XF_BITS-1:0]   xo_next [3][3];
    logic signed [XF_BITS-1:0]   xd_next [3][3];
    logic signed [XF_BITS-1:0]   xo_reg  [3][3];
    logic signed [XF_BITS-1:0]   xd_reg  [3][3];
    logic                        s1_vld_reg;

    assign wo[0] = sat_word(WIDE_BITS'(orig_x));
    assign wo[1] = sat_word(WIDE_BITS'(orig_y));
    assign wo[2] = sat_word(WIDE_BITS'(orig_z));
    assign wd[0] = sat_word(WIDE_BITS'(dir_x));
    assign wd[1] = sat_word(WIDE_BITS'(dir_y));
    assign wd[2] = sat_word(WIDE_BITS'(dir_z));

    always_comb
    begin
        logic signed [XP_BITS-1:0] po;
        logic signed [XP_BITS-1:0] pd;
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                po = XP_BITS'(m[r][k]) * XP_BITS'(wo[k]);
                pd = XP_BITS'(m[r][k]) * XP_BITS'(wd[k]);
                xo_next[r][k] = po[XP_BITS-1:FRAC_BITS];
                xd_next[r][k] = pd[XP_BITS-1:FRAC_BITS];
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 2: object-space origin (with translation) and direction
    // ---------------------------------------------------------------
    logic signed [WORD_BITS-1:0] o_next [3];
    logic signed [WORD_BITS-1:0] d_next [3];
    logic signed [WORD_BITS-1:0] o_reg  [3];
    logic signed [WORD_BITS-1:0] d_reg  [3];
    logic                        s2_vld_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            o_next[r] = sat_word(WIDE_BITS'(xo_reg[r][0]) + WIDE_BITS'(xo_reg[r][1])
                                 + WIDE_BITS'(xo_reg[r][2]) + WIDE_BITS'(m[r][3]));
            d_next[r] = sat_word(WIDE_BITS'(xd_reg[r][0]) + WIDE_BITS'(xd_reg[r][1])
                                 + WIDE_BITS'(xd_reg[r][2]));
        end
    end

    // ---------------------------------------------------------------
    // stage 3: cone products d*d, o*d, o*o, floored
    // ---------------------------------------------------------------
    logic signed [CF_BITS-1:0] dd_next [3];
    logic signed [CF_BITS-1:0] od_next [3];
    logic signed [CF_BITS-1:0] oo_next [3];
    logic signed [CF_BITS-1:0] dd_reg  [3];
    logic signed [CF_BITS-1:0] od_reg  [3];
    logic signed [CF_BITS-1:0] oo_reg  [3];
    logic                      s3_vld_reg;

    always_comb
    begin
        logic signed [CP_BITS-1:0] p_dd;
        logic signed [CP_BITS-1:0] p_od;
        logic signed [CP_BITS-1:0] p_oo;
        for (int k = 0; k < 3; k++)
        begin
            p_dd = CP_BITS'(d_reg[k]) * CP_BITS'(d_reg[k]);
            p_od = CP_BITS'(o_reg[k]) * CP_BITS'(d_reg[k]);
            p_oo = CP_BITS'(o_reg[k]) * CP_BITS'(o_reg[k]);
            dd_next[k] = p_dd[CP_BITS-1:FRAC_BITS];
            od_next[k] = p_od[CP_BITS-1:FRAC_BITS];
            oo_next[k] = p_oo[CP_BITS-1:FRAC_BITS];
        end
    end

    // ---------------------------------------------------------------
    // stage 4: quadratic coefficients a, h = b/2, c (y term subtracts)
    // ---------------------------------------------------------------
    logic signed [WORD_BITS-1:0] a_next, h_next, c_next;
    logic signed [WORD_BITS-1:0] a4_reg, h4_reg, c4_reg;
    logic                        s4_vld_reg;

    assign a_next = sat_word(WIDE_BITS'(dd_reg[0]) - WIDE_BITS'(dd_reg[1])
                             + WIDE_BITS'(dd_reg[2]));
    assign h_next = sat_word(WIDE_BITS'(od_reg[0]) - WIDE_BITS'(od_reg[1])
                             + WIDE_BITS'(od_reg[2]));
    assign c_next = sat_word(WIDE_BITS'(oo_reg[0]) - WIDE_BITS'(oo_reg[1])
                             + WIDE_BITS'(oo_reg[2]));

    // ---------------------------------------------------------------
    // stage 5: h*h and a*c
    // ---------------------------------------------------------------
    logic signed [CP_BITS-1:0]   hh_reg, ac_reg;
    logic signed [WORD_BITS-1:0] a5_reg, h5_reg;
    logic                        degen5_reg;
    logic                        s5_vld_reg;

    // ---------------------------------------------------------------
    // stage 6: quarter discriminant e = h*h - a*c, radicand for the root
    // ---------------------------------------------------------------
    logic signed [CP_BITS:0] e_full;
    logic [RAD_BITS-1:0]     rad_reg;
    sq_side_t                sq_side_reg;
    logic                    s6_vld_reg;

    assign e_full = (CP_BITS+1)'(hh_reg) - (CP_BITS+1)'(ac_reg);

    // ---------------------------------------------------------------
    // square root
    // ---------------------------------------------------------------
    logic                 sq_vld;
    logic [ROOT_BITS-1:0] sq_root;
    sq_side_t             sq_side;

    rci_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .rad      (rad_reg),
        .in_side  (sq_side_reg),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    // ---------------------------------------------------------------
    // stage 7: root numerators -h - s and -h + s
    // ---------------------------------------------------------------
    logic signed [NUM_BITS-1:0]  nn_reg, nf_reg;
    logic signed [WORD_BITS-1:0] a7_reg;
    dv_side_t                    dv_side_reg;
    logic                        s7_vld_reg;
    logic signed [NUM_BITS-1:0]  s_ext;

    assign s_ext = $signed(NUM_BITS'(sq_root));

    // ---------------------------------------------------------------
    // pipeline registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= in_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xo_reg <= xo_next;
            xd_reg <= xd_next;
            o_reg  <= o_next;
            d_reg  <= d_next;
            dd_reg <= dd_next;
            od_reg <= od_next;
            oo_reg <= oo_next;
            a4_reg <= a_next;
            h4_reg <= h_next;
            c4_reg <= c_next;

            hh_reg     <= CP_BITS'(h4_reg) * CP_BITS'(h4_reg);
            ac_reg     <= CP_BITS'(a4_reg) * CP_BITS'(c4_reg);
            a5_reg     <= a4_reg;
            h5_reg     <= h4_reg;
            degen5_reg <= (a4_reg == '0);

            // negative discriminant: root is unused, feed zero
            rad_reg           <= e_full[CP_BITS] ? '0 : e_full[RAD_BITS-1:0];
            sq_side_reg.h     <= h5_reg;
            sq_side_reg.a     <= a5_reg;
            sq_side_reg.degen <= degen5_reg;
            sq_side_reg.e_ok  <= !e_full[CP_BITS];

            nn_reg            <= -NUM_BITS'(sq_side.h) - s_ext;
            nf_reg            <= -NUM_BITS'(sq_side.h) + s_ext;
            a7_reg            <= sq_side.a;
            dv_side_reg.degen <= sq_side.degen;
            dv_side_reg.e_ok  <= sq_side.e_ok;
        end
    end

    // ---------------------------------------------------------------
    // root division and output register
    // ---------------------------------------------------------------
    rci_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (s7_vld_reg),
        .num_near   (nn_reg),
        .num_far    (nf_reg),
        .den        (a7_reg),
        .in_side    (dv_side_reg),
        .out_vld    (out_valid),
        .hit        (hit),
        .degenerate (degenerate),
        .t_near     (t_near),
        .t_far      (t_far)
    );

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_hit_not_degen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !degenerate)
        else $error("hit reported together with degenerate");

    a_miss_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (t_near == '0 && t_far == '0))
        else $error("roots not cleared on a miss");

    a_empty_output_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register is empty");

    a_stall_holds_tail: assert property (@(posedge clk) disable iff (!rst_n)
        s7_vld_reg && !en |=> s7_vld_reg)
        else $error("divider feed transaction lost during stall");

endmodule
